@@ design/slcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// slcrc_pkg
// Shared types, event codes and the word-wide CRC-32 update for the
// start/length framed receiver with CRC check.
// ----------------------------------------------------------------------------
package slcrc_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h7E;
  localparam logic [15:0] HDR_CRC_BYTES = 16'd8;
  localparam logic [31:0] CRC_POLY      = 32'h04C11DB7;

  typedef enum logic [2:0] {
    EV_SKIP    = 3'd0,
    EV_FRAME   = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_CRC_ERR = 3'd4,
    EV_REJECT  = 3'd5
  } event_t;

  typedef struct packed {
    event_t      event_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  command_code;
    logic [15:0] frame_length;
  } result_t;

  typedef logic [31:0] crc_cols_t [32];

  // response of 32 msb-first shift steps to each single input bit
  function automatic crc_cols_t crc_columns();
    crc_cols_t   cols;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'h1 << i;
      for (int k = 0; k < 32; k++) begin
        c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_columns();

  // linear map: xor of the columns selected by the set bits
  function automatic logic [31:0] crc_word(logic [31:0] x);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        acc = acc ^ CRC_COLS[i];
      end
    end
    return acc;
  endfunction

endpackage

@@ design/slcrc_engine.sv @@
// ----------------------------------------------------------------------------
// slcrc_engine
// Frame state machine: hunts for the start byte, takes length and command,
// indexes payload bytes and folds each completed word into the CRC.
// ----------------------------------------------------------------------------
module slcrc_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         max_len,
  output slcrc_pkg::result_t  res
);

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_LEN0    = 9'b000000010,
    PH_LEN1    = 9'b000000100,
    PH_CMD     = 9'b000001000,
    PH_PAYLOAD = 9'b000010000,
    PH_CRC0    = 9'b000100000,
    PH_CRC1    = 9'b001000000,
    PH_CRC2    = 9'b010000000,
    PH_CRC3    = 9'b100000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [23:0] part_r, part_nxt;

  logic [31:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] pos_inc;
  logic        take;
  logic [1:0]  lane;
  logic        hunt;
  logic        is_start;
  logic        reject;

  always_comb begin
    crc_upd   = slcrc_pkg::crc_word(crc_r ^ {rx_byte, part_r});
    is_start  = (rx_byte == slcrc_pkg::START_BYTE);
    len_full  = {rx_byte, len_r[7:0]};
    reject    = (len_full > max_len) || (len_full < slcrc_pkg::HDR_CRC_BYTES) ||
                (len_full[1:0] != 2'b00);
    pos_inc   = pos_r + 16'd1;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    part_nxt  = part_r;
    take      = 1'b0;
    lane      = 2'd0;
    hunt      = 1'b0;
    res       = '0;
    res.event_kind = slcrc_pkg::EV_SKIP;

    case (phase_r)
      PH_LEN0: begin
        len_nxt        = {8'd0, rx_byte};
        take           = 1'b1;
        lane           = 2'd1;
        phase_nxt      = PH_LEN1;
        res.event_kind = slcrc_pkg::EV_FRAME;
      end
      PH_LEN1: begin
        len_nxt          = len_full;
        res.frame_length = len_full;
        if (reject) begin
          res.event_kind = slcrc_pkg::EV_REJECT;
          hunt           = 1'b1;
        end else begin
          take           = 1'b1;
          lane           = 2'd2;
          phase_nxt      = PH_CMD;
          res.event_kind = slcrc_pkg::EV_FRAME;
        end
      end
      PH_CMD: begin
        cmd_nxt          = rx_byte;
        take             = 1'b1;
        lane             = 2'd3;
        pos_nxt          = '0;
        phase_nxt        = (len_r == slcrc_pkg::HDR_CRC_BYTES) ? PH_CRC0 : PH_PAYLOAD;
        res.event_kind   = slcrc_pkg::EV_FRAME;
        res.command_code = rx_byte;
        res.frame_length = len_r;
      end
      PH_PAYLOAD: begin
        take              = 1'b1;
        lane              = pos_r[1:0];
        res.event_kind    = slcrc_pkg::EV_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = pos_r;
        res.command_code  = cmd_r;
        res.frame_length  = len_r;
        pos_nxt           = pos_inc;
        if (pos_inc >= (len_r - slcrc_pkg::HDR_CRC_BYTES)) begin
          phase_nxt = PH_CRC0;
        end
      end
      PH_CRC0: begin
        take             = 1'b1;
        lane             = 2'd0;
        phase_nxt        = PH_CRC1;
        res.event_kind   = slcrc_pkg::EV_FRAME;
        res.command_code = cmd_r;
        res.frame_length = len_r;
      end
      PH_CRC1: begin
        take             = 1'b1;
        lane             = 2'd1;
        phase_nxt        = PH_CRC2;
        res.event_kind   = slcrc_pkg::EV_FRAME;
        res.command_code = cmd_r;
        res.frame_length = len_r;
      end
      PH_CRC2: begin
        take             = 1'b1;
        lane             = 2'd2;
        phase_nxt        = PH_CRC3;
        res.event_kind   = slcrc_pkg::EV_FRAME;
        res.command_code = cmd_r;
        res.frame_length = len_r;
      end
      PH_CRC3: begin
        take             = 1'b1;
        lane             = 2'd3;
        phase_nxt        = PH_HUNT;
        res.event_kind   = (crc_upd == 32'd0) ? slcrc_pkg::EV_GOOD : slcrc_pkg::EV_CRC_ERR;
        res.command_code = cmd_r;
        res.frame_length = len_r;
      end
      default: begin
        hunt           = 1'b1;
        res.event_kind = is_start ? slcrc_pkg::EV_FRAME : slcrc_pkg::EV_SKIP;
      end
    endcase

    if (take) begin
      case (lane)
        2'd0: part_nxt = {16'd0, rx_byte};
        2'd1: part_nxt = part_r | {8'd0, rx_byte, 8'd0};
        2'd2: part_nxt = part_r | {rx_byte, 16'd0};
        2'd3: begin
          crc_nxt  = crc_upd;
          part_nxt = '0;
        end
        default: part_nxt = part_r;
      endcase
    end

    if (hunt) begin
      phase_nxt = PH_HUNT;
      if (is_start) begin
        len_nxt   = '0;
        cmd_nxt   = '0;
        pos_nxt   = '0;
        crc_nxt   = '1;
        part_nxt  = {16'd0, rx_byte};
        phase_nxt = PH_LEN0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      cmd_r   <= '0;
      pos_r   <= '0;
      crc_r   <= '1;
      part_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      part_r  <= part_nxt;
    end
  end

endmodule

@@ design/start_length_crc_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// start_length_crc_frame_receiver_top
// Byte-stream frame receiver: start byte, 16-bit length, command, payload,
// CRC-32 check; one result item for every received byte.
//
// Input channel in_valid/in_stall carries one received byte per item.
// Output channel out_valid/out_stall carries one result item per byte: the
// event kind, payload byte and index, command code and frame length.
// cfg_wr_en/cfg_wr_data write the maximum accepted frame length (reset 1088).
// An item is held in an input register, then passes through the frame state
// machine and the word-wide CRC update into the result register: one item
// per cycle sustained while out_stall is low, set by the 32-bit CRC fold
// that is done combinationally in the state update.
// Reset returns the receiver to hunting for the start byte and empties both
// registers. While out_stall is high with a result waiting, the input
// register still takes one more item, then in_stall rises until the result
// is taken; no item is dropped.
// ----------------------------------------------------------------------------
module start_length_crc_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_command_code,
  output logic [15:0] out_frame_length,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic               s1_vld_r;
  logic [7:0]         s1_byte_r;
  logic               out_vld_r;
  slcrc_pkg::result_t out_res_r;
  slcrc_pkg::result_t res;
  logic [15:0]        max_len_r;
  logic               adv;
  logic               step;

  assign adv      = !out_vld_r || !out_stall;
  assign step     = s1_vld_r && adv;
  assign in_stall = s1_vld_r && !adv;

  slcrc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .max_len (max_len_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 16'd1088;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_kind    = out_res_r.event_kind;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_index = out_res_r.payload_index;
  assign out_command_code  = out_res_r.command_code;
  assign out_frame_length  = out_res_r.frame_length;

endmodule
